### sv/assert_macros.svh
// Assertion macros shared by the chord subset RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is held.
`define MNCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mncs: property check failed");

// Implication check, disabled while reset is held.
`define MNCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mncs: implication check failed");

`endif

### sv/mncs_pkg.sv
// Shared types and constants of the non-crossing chord subset block.
package mncs_pkg;

  localparam int PT_W        = 7;    // endpoint width
  localparam int CNT_W       = 7;    // chosen count width
  localparam int PC_W        = 8;    // point_count register width
  localparam int IDX_W       = 9;    // signed interval index width
  localparam int STACK_DEPTH = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [PC_W-1:0] PC_RESET = 8'd128;
  localparam logic REG_POINT_COUNT = 1'b0;

  typedef struct packed {
    logic ld_wr1;   // request accepted, write first half of the chord
    logic ld_wr2;   // write second half of the chord
    logic f_init;   // start of the interval fill
    logic j_chk;    // new column, fetch partner of j
    logic c1;       // cell read, first step
    logic c2;       // cell read, second step
    logic c3;       // cell compute and write
    logic cnt_rd;   // read best of the whole circle
    logic cnt_lat;  // latch count, start traceback
    logic t_rd;     // traceback read or stack pop
    logic t_chk;    // traceback decision
    logic t_pop;    // popped chord handled
    logic fin;      // final result loaded
  } cmd_t;

  typedef struct packed {
    logic last;
    logic j_lt_n;
    logic i_next_lt_j;
    logic tb_go;
    logic sp_zero;
    logic pop_stall;
    logic out_free;
  } stat_t;

endpackage

### sv/mncs_ctrl.sv
// Controller state machine of the non-crossing chord subset block.
`include "assert_macros.svh"

module mncs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mncs_pkg::stat_t stat,
  output mncs_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_LOAD2 = 4'd1;
  localparam logic [3:0] S_FINIT = 4'd2;
  localparam logic [3:0] S_JCHK  = 4'd3;
  localparam logic [3:0] S_C1    = 4'd4;
  localparam logic [3:0] S_C2    = 4'd5;
  localparam logic [3:0] S_C3    = 4'd6;
  localparam logic [3:0] S_CNT   = 4'd7;
  localparam logic [3:0] S_CNT2  = 4'd8;
  localparam logic [3:0] S_TRD   = 4'd9;
  localparam logic [3:0] S_TCHK  = 4'd10;
  localparam logic [3:0] S_TPOP  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_LOAD: begin
        cmd.ld_wr1 = in_valid;
        if (in_valid) state_nxt = S_LOAD2;
      end
      S_LOAD2: begin
        cmd.ld_wr2 = 1'b1;
        state_nxt = stat.last ? S_FINIT : S_LOAD;
      end
      S_FINIT: begin
        cmd.f_init = 1'b1;
        state_nxt = S_JCHK;
      end
      S_JCHK: begin
        cmd.j_chk = 1'b1;
        state_nxt = stat.j_lt_n ? S_C1 : S_CNT;
      end
      S_C1: begin
        cmd.c1 = 1'b1;
        state_nxt = S_C2;
      end
      S_C2: begin
        cmd.c2 = 1'b1;
        state_nxt = S_C3;
      end
      S_C3: begin
        cmd.c3 = 1'b1;
        state_nxt = stat.i_next_lt_j ? S_C1 : S_JCHK;
      end
      S_CNT: begin
        cmd.cnt_rd = 1'b1;
        state_nxt = S_CNT2;
      end
      S_CNT2: begin
        cmd.cnt_lat = 1'b1;
        state_nxt = S_TRD;
      end
      S_TRD: begin
        cmd.t_rd = 1'b1;
        if (stat.tb_go) state_nxt = S_TCHK;
        else if (stat.sp_zero) state_nxt = S_FIN;
        else state_nxt = S_TPOP;
      end
      S_TCHK: begin
        cmd.t_chk = 1'b1;
        state_nxt = S_TRD;
      end
      S_TPOP: begin
        cmd.t_pop = !stat.pop_stall;
        if (!stat.pop_stall) state_nxt = S_TRD;
      end
      S_FIN: begin
        cmd.fin = stat.out_free;
        if (stat.out_free) state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  `MNCS_ASSERT_IMPL(a_load2_after_load, clk, rst_n, state_r == S_LOAD2, $past(state_r) == S_LOAD)
  `MNCS_ASSERT_IMPL(a_fin_needs_room, clk, rst_n, cmd.fin, stat.out_free)
  `MNCS_ASSERT_IMPL(a_pop_after_read, clk, rst_n, state_r == S_TPOP,
    $past(state_r) == S_TRD || $past(state_r) == S_TPOP)

endmodule

### sv/mncs_dp.sv
// Datapath of the non-crossing chord subset block: tables, indices, stack and result register.
`include "assert_macros.svh"

module mncs_dp #(
  parameter int MAX_POINTS = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mncs_pkg::cmd_t               cmd,
  output mncs_pkg::stat_t              stat,
  input  logic [mncs_pkg::PC_W-1:0]    point_count,
  input  logic [mncs_pkg::PT_W-1:0]    in_start,
  input  logic [mncs_pkg::PT_W-1:0]    in_end,
  input  logic                         in_last,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [mncs_pkg::CNT_W-1:0]   out_count,
  output logic [mncs_pkg::PT_W-1:0]    out_start,
  output logic [mncs_pkg::PT_W-1:0]    out_end,
  output logic                         out_pvalid,
  output logic                         out_last
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int IW = mncs_pkg::IDX_W;
  localparam int TW = mncs_pkg::PT_W;
  localparam int SW = $clog2(mncs_pkg::STACK_DEPTH);
  localparam int MEM_DEPTH = 1 << (2 * PW);
  localparam logic signed [IW-1:0] ONE = 1;
  localparam logic signed [IW-1:0] MAX_S = IW'(MAX_POINTS);

  // Partner table, interval table {took, best} and traceback stack.
  logic [TW-1:0]     part_mem [MAX_POINTS];
  logic [TW:0]       ivl_mem  [MEM_DEPTH];
  logic [2*PW-1:0]   stk_mem  [mncs_pkg::STACK_DEPTH];
  logic [TW-1:0]     part_rd_r;
  logic [TW:0]       rda_r, rdb_r;
  logic [2*PW-1:0]   stk_rd_r;

  logic [TW-1:0]     s_r, e_r;
  logic              last_r;
  logic [mncs_pkg::PC_W-1:0] n_r;
  logic signed [IW-1:0] i_r, j_r;
  logic [TW-1:0]     left_r;
  logic [mncs_pkg::CNT_W-1:0] cnt_r;
  logic [SW:0]       sp_r;
  logic [mncs_pkg::CNT_W-1:0] prod_r;
  logic              pend_v_r;
  logic [TW-1:0]     pend_s_r, pend_e_r;
  logic              out_valid_r;
  logic [mncs_pkg::CNT_W-1:0] out_cnt_r;
  logic [TW-1:0]     out_s_r, out_e_r;
  logic              out_pv_r, out_last_r;

  logic signed [IW-1:0] kk, km1, kp1, jm1, nn;
  logic keep_ok, left_ok, right_ok, take, out_free, prod_ok;
  logic [TW-1:0] keep, right;
  logic [TW:0] cand;
  logic part_we, part_re, rea, reb, stk_push, stk_pop;
  logic [PW-1:0] part_wa;
  logic [TW-1:0] part_wd;
  logic signed [IW-1:0] a_i, a_j, b_i, b_j;
  logic [PW-1:0] pk, pj;

  assign kk  = $signed({{(IW-TW){1'b0}}, part_rd_r});
  assign km1 = kk - ONE;
  assign kp1 = kk + ONE;
  assign jm1 = j_r - ONE;
  assign nn  = $signed({{(IW-mncs_pkg::PC_W){1'b0}}, n_r});
  assign pk  = stk_rd_r[2*PW-1:PW];
  assign pj  = stk_rd_r[PW-1:0];

  assign keep_ok  = jm1 > i_r;
  assign left_ok  = (km1 > i_r) && (km1 < MAX_S);
  assign right_ok = jm1 > kp1;
  assign keep  = keep_ok  ? rda_r[TW-1:0] : '0;
  assign right = right_ok ? rdb_r[TW-1:0] : '0;
  assign cand  = {1'b0, left_r} + {1'b0, right} + (TW+1)'(1);
  assign take  = (part_rd_r == '0) ? (i_r == '0)
               : ((i_r <= kk) && (kk < j_r) && ({1'b0, keep} < cand));

  assign out_free = !out_valid_r || out_ready;
  assign prod_ok  = prod_r < mncs_pkg::CNT_W'(mncs_pkg::RESULT_LIMIT);

  assign stat.last        = last_r;
  assign stat.j_lt_n      = j_r < nn;
  assign stat.i_next_lt_j = (i_r + ONE) < j_r;
  assign stat.tb_go       = j_r > i_r;
  assign stat.sp_zero     = (sp_r == '0);
  assign stat.pop_stall   = pend_v_r && prod_ok && !out_free;
  assign stat.out_free    = out_free;

  // Partner table port control.
  always_comb begin
    part_we = 1'b0;
    part_wa = in_start[PW-1:0];
    part_wd = in_end;
    if (cmd.ld_wr1) begin
      part_we = int'(in_start) < MAX_POINTS;
    end else if (cmd.ld_wr2) begin
      part_we = int'(e_r) < MAX_POINTS;
      part_wa = e_r[PW-1:0];
      part_wd = s_r;
    end
  end

  assign part_re = (cmd.j_chk && stat.j_lt_n) || (cmd.t_rd && stat.tb_go);

  always_ff @(posedge clk) begin
    if (part_we) part_mem[part_wa] <= part_wd;
    if (part_re) part_rd_r <= part_mem[j_r[PW-1:0]];
  end

  // Interval table ports.
  always_comb begin
    a_i = i_r;
    a_j = jm1;
    if (cmd.cnt_rd) begin
      a_i = '0;
      a_j = nn - ONE;
    end else if (cmd.t_rd) begin
      a_j = j_r;
    end
    b_i = i_r;
    b_j = km1;
    if (cmd.c2) begin
      b_i = kp1;
      b_j = jm1;
    end
  end

  assign rea = cmd.c1 || cmd.cnt_rd || (cmd.t_rd && stat.tb_go);
  assign reb = cmd.c1 || cmd.c2;

  always_ff @(posedge clk) begin
    if (cmd.c3) begin
      ivl_mem[{i_r[PW-1:0], j_r[PW-1:0]}] <= take ? {1'b1, cand[TW-1:0]} : {1'b0, keep};
    end
    if (rea) rda_r <= ivl_mem[{a_i[PW-1:0], a_j[PW-1:0]}];
    if (reb) rdb_r <= ivl_mem[{b_i[PW-1:0], b_j[PW-1:0]}];
  end

  // Traceback stack.
  assign stk_push = cmd.t_chk && rda_r[TW] && (sp_r < (SW+1)'(mncs_pkg::STACK_DEPTH));
  assign stk_pop  = cmd.t_rd && !stat.tb_go && (sp_r != '0);

  always_ff @(posedge clk) begin
    if (stk_push) stk_mem[sp_r[SW-1:0]] <= {kk[PW-1:0], j_r[PW-1:0]};
    if (stk_pop) stk_rd_r <= stk_mem[sp_r[SW-1:0] - SW'(1)];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_wr1) begin
      s_r <= in_start;
      e_r <= in_end;
    end
    if (cmd.c2) left_r <= left_ok ? rdb_r[TW-1:0] : '0;
    if (cmd.cnt_lat) cnt_r <= (nn > ONE) ? rda_r[TW-1:0] : '0;
    if (cmd.t_pop && prod_ok) begin
      pend_s_r <= TW'(pk);
      pend_e_r <= TW'(pj);
    end
    if (cmd.t_pop && prod_ok && pend_v_r) begin
      out_cnt_r  <= cnt_r;
      out_s_r    <= pend_s_r;
      out_e_r    <= pend_e_r;
      out_pv_r   <= 1'b1;
      out_last_r <= 1'b0;
    end else if (cmd.fin) begin
      out_cnt_r  <= cnt_r;
      out_s_r    <= pend_v_r ? pend_s_r : '0;
      out_e_r    <= pend_v_r ? pend_e_r : '0;
      out_pv_r   <= pend_v_r;
      out_last_r <= 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      sp_r        <= '0;
      prod_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ld_wr1) last_r <= in_last;
      if (cmd.f_init) begin
        n_r <= (int'(point_count) > MAX_POINTS) ? mncs_pkg::PC_W'(MAX_POINTS) : point_count;
        i_r <= '0;
        j_r <= ONE;
      end
      if (cmd.j_chk) i_r <= '0;
      if (cmd.c3) begin
        if (stat.i_next_lt_j) i_r <= i_r + ONE;
        else j_r <= j_r + ONE;
      end
      if (cmd.cnt_lat) begin
        i_r      <= '0;
        j_r      <= nn - ONE;
        sp_r     <= '0;
        prod_r   <= '0;
        pend_v_r <= 1'b0;
      end
      if (stk_pop) sp_r <= sp_r - (SW+1)'(1);
      if (stk_push) sp_r <= sp_r + (SW+1)'(1);
      if (cmd.t_chk) j_r <= rda_r[TW] ? km1 : jm1;
      if (cmd.t_pop) begin
        i_r <= IW'(pk) + ONE;
        j_r <= IW'(pj) - ONE;
        if (prod_ok) begin
          prod_r   <= prod_r + mncs_pkg::CNT_W'(1);
          pend_v_r <= 1'b1;
        end
      end
      if ((cmd.t_pop && prod_ok && pend_v_r) || cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_count  = out_cnt_r;
  assign out_start  = out_s_r;
  assign out_end    = out_e_r;
  assign out_pvalid = out_pv_r;
  assign out_last   = out_last_r;

  `MNCS_ASSERT(a_sp_bound, clk, rst_n, sp_r <= (SW+1)'(mncs_pkg::STACK_DEPTH))
  `MNCS_ASSERT(a_prod_bound, clk, rst_n,
    prod_r <= mncs_pkg::CNT_W'(mncs_pkg::RESULT_LIMIT))

endmodule

### sv/max_noncrossing_chord_subset_core.sv
// Top level of the maximum non-crossing chord subset block.
//
// Usage: each request on the in_ channel carries one chord of a circle
// (chord_start, chord_end) and in_tlast marks the final chord of a run.
// Every chord is entered both ways into a partner table; while loading, no
// request is taken before the last one's second half is written. The request
// with in_tlast set starts the interval fill: one column per point, each
// interval cell taking two read steps and a write step, plus a partner fetch
// step per column. The fill is bounded by the single interval table, which
// has one write and two read ports. A traceback over a 64-entry stack
// follows, each walk step a read and a decision and each popped chord a read
// and a pop, and emits one result per chosen chord in start order on the
// out_ channel, with out_tlast on the final one. If no chord is chosen, a
// single result with out_tuser low is sent. When the receiver stalls, the
// traceback waits with one result held in the output register and one
// pending. point_count is written over the cfg_ APB port between runs. Reset
// returns the block to loading with point_count at 128; the tables keep no
// valid state and are rebuilt by each run.
module max_noncrossing_chord_subset_core #(
  parameter int MAX_POINTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: chord_start [6:0], chord_end [13:7], zero [15:14]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tlast,
  // out_tdata: chosen_count [6:0], picked_start [13:7], picked_end [20:14], zero [23:21]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // out_tuser: picked_valid [0]
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [mncs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mncs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mncs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic        cfg_pready
);

  mncs_pkg::cmd_t  cmd;
  mncs_pkg::stat_t stat;

  logic [mncs_pkg::PC_W-1:0]  point_count_r;
  logic [mncs_pkg::CNT_W-1:0] res_count;
  logic [mncs_pkg::PT_W-1:0]  res_start, res_end;
  logic                       cfg_sel_pc;

  // The register index is the word address; only point_count exists.
  assign cfg_pready = 1'b1;
  assign cfg_sel_pc = (cfg_paddr[2] == mncs_pkg::REG_POINT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= mncs_pkg::PC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_pc) begin
      point_count_r <= cfg_pwdata[mncs_pkg::PC_W-1:0];
    end
  end

  assign cfg_prdata = cfg_sel_pc ? mncs_pkg::CFG_DW'(point_count_r) : '0;

  mncs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mncs_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .point_count (point_count_r),
    .in_start    (in_tdata[6:0]),
    .in_end      (in_tdata[13:7]),
    .in_last     (in_tlast),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_count   (res_count),
    .out_start   (res_start),
    .out_end     (res_end),
    .out_pvalid  (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {3'b000, res_end, res_start, res_count};

endmodule

### test/chord_subset_checker.sv
// Checker of the non-crossing chord subset block: predicts each run and compares its results.
module chord_subset_checker
  import mncs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic              in_tlast,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [23:0]       out_tdata,
  input  logic              out_tuser,
  input  logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending_count
);

  localparam int NPTS = 128;
  localparam logic [CFG_AW-1:0] POINT_COUNT_ADDR = CFG_AW'(4 * REG_POINT_COUNT);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [PT_W-1:0]  pick_lo;
    logic [PT_W-1:0]  pick_hi;
    logic             has_pick;
    logic             final_pick;
  } pick_t;

  logic [PC_W-1:0]  points_reg;
  logic [PT_W-1:0]  partner_of [NPTS];
  logic [CNT_W-1:0] best_tab [NPTS][NPTS];
  bit               took_tab [NPTS][NPTS];
  pick_t            picks_q [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    points_reg    = PC_RESET;
    for (int p = 0; p < NPTS; p++) partner_of[p] = '0;
  end

  function automatic int best_at(int i, int j);
    if (i < 0 || j <= i || j >= NPTS) return 0;
    return int'(best_tab[i][j]);
  endfunction

  // Fills the interval table for the current point count and walks it back.
  task automatic predict_chord_run();
    int    n, k, keep, cand, i, j, sp, count;
    bit    take;
    int    stk_lo [STACK_DEPTH];
    int    stk_hi [STACK_DEPTH];
    pick_t run_q [$];
    pick_t pk;
    n = (int'(points_reg) > NPTS) ? NPTS : int'(points_reg);
    for (j = 0; j < n; j++) begin
      k = int'(partner_of[j]);
      for (i = 0; i < j; i++) begin
        keep = best_at(i, j - 1);
        cand = best_at(i, k - 1) + best_at(k + 1, j - 1) + 1;
        if (k == 0) take = (i == 0);
        else        take = (i <= k) && (k < j) && (keep < cand);
        best_tab[i][j] = take ? CNT_W'(cand) : CNT_W'(keep);
        took_tab[i][j] = take;
      end
    end
    count = best_at(0, n - 1);
    sp = 0;
    i  = 0;
    j  = n - 1;
    while (1) begin
      while (j > i && !took_tab[i][j]) j--;
      if (j > i) begin
        k = int'(partner_of[j]);
        if (sp < STACK_DEPTH) begin
          stk_lo[sp] = k;
          stk_hi[sp] = j;
          sp++;
        end
        j = k - 1;
        continue;
      end
      if (sp == 0) break;
      sp--;
      if (run_q.size() < RESULT_LIMIT) begin
        pk.count      = CNT_W'(count);
        pk.pick_lo    = PT_W'(stk_lo[sp]);
        pk.pick_hi    = PT_W'(stk_hi[sp]);
        pk.has_pick   = 1'b1;
        pk.final_pick = 1'b0;
        run_q.push_back(pk);
      end
      i = stk_lo[sp] + 1;
      j = stk_hi[sp] - 1;
    end
    if (run_q.size() == 0) begin
      pk = '0;
      pk.count = CNT_W'(count);
      run_q.push_back(pk);
    end
    pk = run_q.pop_back();
    pk.final_pick = 1'b1;
    run_q.push_back(pk);
    foreach (run_q[q]) picks_q.push_back(run_q[q]);
  endtask

  always @(posedge clk) begin
    pick_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (picks_q.size() == 0) begin
          $error("unexpected result: tdata %h tuser %b tlast %b",
                 out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = picks_q.pop_front();
          if (out_tdata[6:0] !== want.count) begin
            $error("chosen_count: expected %0d, got %0d", want.count, out_tdata[6:0]);
            fail_count++;
          end
          if (out_tdata[13:7] !== want.pick_lo) begin
            $error("picked_start: expected %0d, got %0d", want.pick_lo, out_tdata[13:7]);
            fail_count++;
          end
          if (out_tdata[20:14] !== want.pick_hi) begin
            $error("picked_end: expected %0d, got %0d", want.pick_hi, out_tdata[20:14]);
            fail_count++;
          end
          if (out_tuser !== want.has_pick) begin
            $error("picked_valid: expected %0d, got %0d", want.has_pick, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.final_pick) begin
            $error("last_result: expected %0d, got %0d", want.final_pick, out_tlast);
            fail_count++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == POINT_COUNT_ADDR)
        points_reg = cfg_pwdata[PC_W-1:0];
      if (in_tvalid && in_tready) begin
        partner_of[in_tdata[6:0]]  = in_tdata[13:7];
        partner_of[in_tdata[13:7]] = in_tdata[6:0];
        if (in_tlast) predict_chord_run();
      end
      pending_count <= picks_q.size();
    end
  end

endmodule

### test/max_noncrossing_chord_subset_core_tb.sv
// Testbench top of the non-crossing chord subset block: stimulus, watchdog and verdict.
module max_noncrossing_chord_subset_core_tb;
  import mncs_pkg::*;

  // Idle cycles allowed without any accepted request, result or register access.
  localparam int IDLE_LIMIT = 150000;
  localparam int LONG_HOLD  = 3000;
  localparam int ITEM_GOAL  = 420;
  localparam logic [CFG_AW-1:0] POINT_COUNT_ADDR = CFG_AW'(4 * REG_POINT_COUNT);

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata    = '0;
  logic              in_tlast    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [23:0]       out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending_count;
  int idle_cycles = 0;
  int items_sent  = 0;
  bit hold_req    = 0;   // asks the receiver for one long stall
  bit send_fast   = 0;   // no gaps on the request side for the current run

  always #5 clk = ~clk;

  max_noncrossing_chord_subset_core dut (.*);

  chord_subset_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending_count
  );

  // Watchdog: any accepted request, result or register access restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: a random stall before every result, now and then a run of
  // results with no stall, and one long hold-off when asked.
  initial begin
    int stall;
    int fast_left;
    fast_left = 0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        stall = LONG_HOLD;
        hold_req = 0;
      end else if (fast_left > 0) begin
        stall = 0;
        fast_left--;
      end else begin
        stall = $urandom_range(0, 5);
        if ($urandom_range(0, 19) == 0) fast_left = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // One chord request; the gap before it is drawn per request, or zero in a fast run.
  task automatic send_chord(input int s, input int e, input bit last);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, PT_W'(e), PT_W'(s)};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Writes point_count once the block is idle: every result in and a pause
  // for anything still in flight.
  task automatic set_points(input int value);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (60) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= POINT_COUNT_ADDR;
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // A run: a random perfect matching that covers every point below the count,
  // so no unwritten partner is ever read. A broken run mixes in stray chords,
  // self chords and reused points between the matching chords.
  task automatic send_run(input int npts, input bit broken);
    int m, a, b, tmp, pairs, p;
    int pts [128];
    m = (npts < 2) ? 2 : ((npts + 1) & ~1);
    if (m > 128) m = 128;
    for (p = 0; p < m; p++) pts[p] = p;
    for (p = m - 1; p > 0; p--) begin
      a = $urandom_range(0, p);
      tmp = pts[p];
      pts[p] = pts[a];
      pts[a] = tmp;
    end
    send_fast = ($urandom_range(0, 3) == 0);
    pairs = m / 2;
    for (p = 0; p < pairs; p++) begin
      if (broken && $urandom_range(0, 3) == 0) begin
        a = $urandom_range(0, 127);
        b = ($urandom_range(0, 2) == 0) ? a : $urandom_range(0, 127);
        send_chord(a, b, 1'b0);
      end
      a = pts[2*p];
      b = pts[2*p + 1];
      if ($urandom_range(0, 1)) send_chord(a, b, p == pairs - 1);
      else                      send_chord(b, a, p == pairs - 1);
    end
  endtask

  function automatic int draw_points();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 2 * $urandom_range(1, 8);
    if (r < 95) return $urandom_range(2, 40);
    return 2 * $urandom_range(21, 40);
  endfunction

  initial begin
    int npts, p;
    bit pressed;
    pressed = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nested chords, all taken.
    set_points(4);
    send_chord(0, 3, 1'b0);
    send_chord(2, 1, 1'b1);
    // Side by side chords, and a chord that lands on point zero.
    send_chord(1, 0, 1'b0);
    send_chord(3, 2, 1'b1);
    // Smallest circle.
    set_points(2);
    send_chord(1, 0, 1'b1);
    // All chords crossing: only one is kept.
    set_points(6);
    send_chord(0, 3, 1'b0);
    send_chord(4, 1, 1'b0);
    send_chord(2, 5, 1'b1);
    // Point counts of zero and one: nothing is chosen.
    set_points(0);
    send_chord(0, 1, 1'b1);
    set_points(1);
    send_chord(127, 0, 1'b1);
    // A self chord and an inconsistent pair before the final chord.
    set_points(4);
    send_chord(0, 1, 1'b0);
    send_chord(2, 3, 1'b0);
    send_chord(3, 3, 1'b0);
    send_chord(1, 2, 1'b1);
    // Largest circle, fully nested, so the count reaches its maximum.
    set_points(128);
    for (p = 0; p < 64; p++) send_chord(p, 127 - p, p == 63);
    // Odd count, and a count above the maximum that saturates.
    set_points(7);
    send_run(7, 1'b0);
    set_points(255);
    send_run(128, 1'b1);

    npts = 10;
    set_points(npts);
    while (items_sent < ITEM_GOAL) begin
      if (!pressed && items_sent > 200) begin
        // The receiver stalls while runs keep coming, so the block backs up.
        npts = 16;
        set_points(npts);
        hold_req = 1;
        send_run(npts, 1'b0);
        send_run(npts, 1'b0);
        send_run(npts, 1'b1);
        pressed = 1;
      end else begin
        if (npts > 40 || $urandom_range(0, 3) == 0) begin
          npts = draw_points();
          set_points(npts);
        end
        send_run(npts, $urandom_range(0, 2) == 0);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending_count != 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/mncs_pkg.sv
sv/mncs_ctrl.sv
sv/mncs_dp.sv
sv/max_noncrossing_chord_subset_core.sv
test/chord_subset_checker.sv
test/max_noncrossing_chord_subset_core_tb.sv
